// ----- hdl/csp_pkg.sv -----
package csp_pkg;

    localparam int LINE_MAX_DEF = 48;
    localparam logic [15:0] PIXEL_LIMIT_RST = 16'd639;
    localparam logic [16:0] NUM_MAX = 17'd65535;

    typedef enum logic [2:0] {
        K_PONG = 3'd0,
        K_ACK  = 3'd1,
        K_PIX  = 3'd2,
        K_NA   = 3'd3,
        K_BAD  = 3'd4
    } t_kind;

    // parse modes of the line walk
    typedef enum logic [3:0] {
        M_HEAD, M_PONG_NUM, M_ACK_RUN, M_ACK_TASK, M_ACK_WORD, M_X_BODY, M_FAIL
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_READ, S_STEP, S_DONE, S_OUT
    } t_state;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // controller to datapath
    typedef struct packed {
        logic byte_in;     // a word was accepted
        logic clr_walk;    // start the line walk
        logic read;        // issue store read at walk index
        logic step;        // consume read byte
        logic finish;      // commit result registers
        logic out_take;    // result taken
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic line_end;    // accepted byte ends a non-empty line
        logic walk_last;   // walk index at line end
    } t_sts;

    function automatic logic [4:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
        if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            return {1'b0, c[3:0] + 4'd9};
        return 5'h10;
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

// ----- hdl/csp_ram.sv -----
module csp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- hdl/csp_ctrl.sv -----
module csp_ctrl import csp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    output logic   o_valid,
    input  logic   i_stall,
    input  t_sts   i_sts,
    output t_cmd   o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // sequence: take word, walk the stored line, present result
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.byte_in = 1'b1;
                    if (i_sts.line_end) begin
                        o_cmd.clr_walk = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                if (i_sts.walk_last) n_state = S_DONE;
                else begin
                    o_cmd.read = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state = S_READ;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    o_cmd.out_take = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- hdl/csp_dp.sv -----
module csp_dp import csp_pkg::*; #(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [2:0]  o_line_kind,
    output logic        o_was_x_line,
    output logic [15:0] o_pong_id,
    output logic [15:0] o_run_id,
    output logic [2:0]  o_task_id,
    output logic        o_start_flag,
    output logic [15:0] o_pixel,
    output logic        o_pixel_valid,
    output logic [31:0] o_good_frames,
    output logic [31:0] o_bad_frames,
    output logic [31:0] o_bytes_seen,
    output logic [31:0] o_x_sequence
);
    localparam int AW = $clog2(LINE_MAX);
    localparam int LW = $clog2(LINE_MAX + 1);

    logic [15:0]   r_limit;
    logic [LW-1:0] r_len, r_end, r_idx;
    logic          r_cap;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          wr_en;

    // walk context
    t_mode       r_mode;
    logic [2:0]  r_pos;        // position inside header or word
    logic [16:0] r_num;
    logic        r_any;
    logic [7:0]  r_sum;
    logic        r_star;       // star seen
    logic [1:0]  r_hcnt;       // hex digits after star
    logic [7:0]  r_hex;
    logic        r_hbad;
    logic        r_isx;
    logic [15:0] r_run;
    logic [2:0]  r_task;
    logic        r_stw;        // word is START so far
    logic        r_spw;        // word is STOP so far
    logic [7:0]  r_first;

    logic [15:0] r_pong, r_runh, r_pix;
    logic [2:0]  r_taskh, r_kind;
    logic        r_starth, r_pixv, r_wasx;
    logic [31:0] r_good, r_bad, r_bytes, r_xcnt;

    wire is_end  = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
    assign wr_en = i_cmd.byte_in && r_cap && !is_end && (i_rx_byte != CH_DOLLAR)
                   && (r_len < LW'(LINE_MAX));
    assign o_sts.line_end  = r_cap && is_end && (r_len != '0) && (i_rx_byte != CH_DOLLAR);
    assign o_sts.walk_last = (r_idx == r_end);
    assign rd_addr = r_idx[AW-1:0];

    csp_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(r_len[AW-1:0]),
        .i_wdata(i_rx_byte),
        .i_raddr(rd_addr),
        .o_rdata(rd_data)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_limit <= PIXEL_LIMIT_RST;
        else if (i_cfg_we) r_limit <= i_cfg_data;
    end

    // capture control and byte counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0; r_cap <= 1'b0; r_bytes <= '0;
        end else if (i_cmd.byte_in) begin
            r_bytes <= r_bytes + 32'd1;
            if (i_rx_byte == CH_DOLLAR) begin
                r_len <= '0; r_cap <= 1'b1;
            end else if (r_cap) begin
                if (is_end) begin
                    r_len <= '0; r_cap <= 1'b0;
                end else if (r_len < LW'(LINE_MAX)) r_len <= r_len + 1'b1;
                else r_cap <= 1'b0;
            end
        end
    end

    // digit accumulate
    logic [16:0] num_nx;
    logic [20:0] num_w;
    logic        num_ovf;
    logic [4:0]  hx;
    assign num_w   = {4'd0, r_num} * 21'd10 + {17'd0, rd_data[3:0]};
    assign num_ovf = num_w > {4'd0, NUM_MAX};
    assign num_nx  = num_w[16:0];
    assign hx      = hex_val(rd_data);

    // characters expected in headers and words
    function automatic logic [7:0] pong_ch(input logic [2:0] p);
        case (p)
            3'd0: return 8'h50; 3'd1: return 8'h4F; 3'd2: return 8'h4E;
            3'd3: return 8'h47; default: return CH_COMMA;
        endcase
    endfunction
    function automatic logic [7:0] start_ch(input logic [2:0] p);
        case (p)
            3'd0: return 8'h53; 3'd1: return 8'h54; 3'd2: return 8'h41;
            3'd3: return 8'h52; default: return 8'h54;
        endcase
    endfunction
    function automatic logic [7:0] stop_ch(input logic [2:0] p);
        case (p)
            3'd0: return 8'h53; 3'd1: return 8'h54; 3'd2: return 8'h4F;
            default: return 8'h50;
        endcase
    endfunction

    // walk the line one byte per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_walk) begin
            r_end  <= r_len; r_idx <= '0; r_mode <= M_HEAD; r_pos <= '0;
            r_num  <= '0; r_any <= 1'b0; r_sum <= '0; r_star <= 1'b0;
            r_hcnt <= '0; r_hex <= '0; r_hbad <= 1'b0; r_isx <= 1'b0;
            r_stw  <= 1'b1; r_spw <= 1'b1;
        end else if (i_cmd.read) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.step) begin
            if (r_idx == LW'(1)) r_first <= rd_data;
            if (r_idx == LW'(2)) r_isx <= (r_first == 8'h58) && (rd_data == CH_COMMA);
            if (r_star) begin
                if (r_hcnt != 2'd3) r_hcnt <= r_hcnt + 2'd1;
                if (hx[4]) r_hbad <= 1'b1;
                r_hex <= {r_hex[3:0], hx[3:0]};
            end else if (rd_data == CH_STAR) begin
                r_star <= 1'b1;
                // body end: close the field being parsed
                case (r_mode)
                    M_PONG_NUM, M_X_BODY: if (!r_any) r_mode <= M_FAIL;
                    M_ACK_WORD: if (!((r_stw && r_pos == 3'd5) ||
                                      (r_spw && r_pos == 3'd4))) r_mode <= M_FAIL;
                    default: r_mode <= M_FAIL;
                endcase
            end else begin
                r_sum <= r_sum ^ rd_data;
                case (r_mode)
                    M_HEAD: begin
                        r_pos <= r_pos + 3'd1;
                        // header: PONG, ACK, or X,
                        if (r_pos == 3'd0 && rd_data == 8'h58) r_stw <= 1'b1;
                        if (r_pos == 3'd1 && r_first == 8'h58) begin
                            if (rd_data == CH_COMMA) begin
                                r_mode <= M_X_BODY; r_pos <= 3'd0;
                            end else r_mode <= M_FAIL;
                        end else if (r_pos == 3'd3 && r_first == 8'h41) begin
                            if (rd_data == CH_COMMA && r_spw) begin
                                r_mode <= M_ACK_RUN; r_pos <= 3'd0;
                            end else r_mode <= M_FAIL;
                        end else if (r_pos == 3'd4 && r_first == 8'h50) begin
                            if (rd_data == CH_COMMA && r_stw) begin
                                r_mode <= M_PONG_NUM; r_pos <= 3'd0;
                            end else r_mode <= M_FAIL;
                        end
                        if (r_pos == 3'd0) r_first <= rd_data;
                        // track PONG and ACK prefixes in the word flags
                        if (rd_data != pong_ch(r_pos)) r_stw <= 1'b0;
                        if (rd_data != ((r_pos == 3'd0) ? 8'h41 :
                                        (r_pos == 3'd1) ? 8'h43 : 8'h4B)) r_spw <= 1'b0;
                        if (r_pos == 3'd0 && rd_data != 8'h50 && rd_data != 8'h41 &&
                            rd_data != 8'h58) r_mode <= M_FAIL;
                    end
                    M_PONG_NUM, M_ACK_RUN, M_ACK_TASK: begin
                        if (is_dig(rd_data)) begin
                            if (num_ovf) r_mode <= M_FAIL;
                            r_num <= num_nx; r_any <= 1'b1;
                        end else if (rd_data == CH_COMMA && r_any &&
                                     r_mode != M_PONG_NUM) begin
                            r_num <= '0; r_any <= 1'b0;
                            if (r_mode == M_ACK_RUN) begin
                                r_run <= r_num[15:0]; r_mode <= M_ACK_TASK;
                            end else if (r_num >= 17'd1 && r_num <= 17'd6) begin
                                r_task <= r_num[2:0]; r_mode <= M_ACK_WORD;
                                r_pos <= '0; r_stw <= 1'b1; r_spw <= 1'b1;
                            end else r_mode <= M_FAIL;
                        end else r_mode <= M_FAIL;
                    end
                    M_ACK_WORD: begin
                        if (r_pos == 3'd5 || rd_data != start_ch(r_pos)) r_stw <= 1'b0;
                        if (r_pos >= 3'd4 || rd_data != stop_ch(r_pos)) r_spw <= 1'b0;
                        if (r_pos != 3'd7) r_pos <= r_pos + 3'd1;
                    end
                    M_X_BODY: begin
                        // NA or digits
                        if (is_dig(rd_data) && r_pos == 3'd0) begin
                            if (num_ovf) r_mode <= M_FAIL;
                            r_num <= num_nx; r_any <= 1'b1;
                        end else if (!r_any && r_pos == 3'd0 && rd_data == 8'h4E) begin
                            r_pos <= 3'd1;
                        end else if (r_pos == 3'd1 && rd_data == 8'h41) begin
                            r_pos <= 3'd2; r_any <= 1'b1;
                        end else r_mode <= M_FAIL;
                    end
                    default: ;
                endcase
            end
        end
    end

    // judge the walked line
    logic        ck_ok, good;
    t_kind       kind;
    always_comb begin
        ck_ok = r_star && r_hcnt == 2'd2 && !r_hbad && r_hex == r_sum && r_end > LW'(3);
        kind = K_BAD;
        if (ck_ok) begin
            case (r_mode)
                M_PONG_NUM: kind = K_PONG;
                M_ACK_WORD: kind = K_ACK;
                M_X_BODY:   kind = (r_pos == 3'd2) ? K_NA :
                                   (r_num <= {1'b0, r_limit}) ? K_PIX : K_BAD;
                default:    kind = K_BAD;
            endcase
        end
        good = (kind != K_BAD);
    end

    // commit result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pong <= '0; r_runh <= '0; r_taskh <= '0; r_starth <= 1'b0;
            r_pix <= '0; r_pixv <= 1'b0; r_good <= '0; r_bad <= '0; r_xcnt <= '0;
        end else if (i_cmd.finish) begin
            r_kind <= kind;
            r_wasx <= r_isx;
            if (good) r_good <= r_good + 32'd1;
            else      r_bad  <= r_bad + 32'd1;
            if (r_isx) begin
                r_xcnt <= r_xcnt + 32'd1;
                r_pixv <= (kind == K_PIX);
            end
            if (kind == K_PONG) r_pong <= r_num[15:0];
            if (kind == K_ACK) begin
                r_runh <= r_run; r_taskh <= r_task; r_starth <= r_stw;
            end
            if (kind == K_PIX) r_pix <= r_num[15:0];
        end
    end

    assign o_line_kind   = r_kind;
    assign o_was_x_line  = r_wasx;
    assign o_pong_id     = r_pong;
    assign o_run_id      = r_runh;
    assign o_task_id     = r_taskh;
    assign o_start_flag  = r_starth;
    assign o_pixel       = r_pix;
    assign o_pixel_valid = r_pixv;
    assign o_good_frames = r_good;
    assign o_bad_frames  = r_bad;
    assign o_bytes_seen  = r_bytes;
    assign o_x_sequence  = r_xcnt;
endmodule

// ----- hdl/checksummed_sentence_parser.sv -----
// A byte that is not a line end is taken without leaving the idle state.
// A line end walks the stored line over the single store read port, each byte
// read in S_READ and consumed in S_STEP; S_DONE commits, S_OUT presents.
// Throughput: one word per cycle in a line; input stalls until the result is taken.
// Reset: synchronous active low; clears counters, capture state and held values
// but line_kind and was_x_line, restores pixel_limit to 639; line store not cleared.
module checksummed_sentence_parser import csp_pkg::*; #(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_line_kind,
    output logic        o_was_x_line,
    output logic [15:0] o_pong_id,
    output logic [15:0] o_run_id,
    output logic [2:0]  o_task_id,
    output logic        o_start_flag,
    output logic [15:0] o_pixel,
    output logic        o_pixel_valid,
    output logic [31:0] o_good_frames,
    output logic [31:0] o_bad_frames,
    output logic [31:0] o_bytes_seen,
    output logic [31:0] o_x_sequence
);
    t_cmd cmd;
    t_sts sts;

    csp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
        .i_sts(sts), .o_cmd(cmd)
    );

    csp_dp #(.LINE_MAX(LINE_MAX)) u_dp (
        .i_clk, .i_rst_n, .i_rx_byte, .i_cfg_we, .i_cfg_data,
        .i_cmd(cmd), .o_sts(sts),
        .o_line_kind, .o_was_x_line, .o_pong_id, .o_run_id, .o_task_id,
        .o_start_flag, .o_pixel, .o_pixel_valid, .o_good_frames,
        .o_bad_frames, .o_bytes_seen, .o_x_sequence
    );

    // a result holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_good_frames) && $stable(o_line_kind))
        else $error("result changed while stalled");

    // one frame counter advances per delivered result
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(o_good_frames) != o_good_frames) ||
                           ($past(o_bad_frames) != o_bad_frames))
        else $error("frame counters did not advance");

    // no input taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open during result");
endmodule
